@@ design/gra_pkg.sv @@
package gra_pkg;

   localparam int ENTRY_COUNT_DEFAULT    = 2048;
   localparam int RESERVED_COUNT_DEFAULT = 8;

   localparam int ACTION_WIDTH = 3;
   localparam int DOMAIN_WIDTH = 16;
   localparam int FRAME_WIDTH  = 32;
   localparam int PEER_WIDTH   = 4;
   localparam int STATUS_WIDTH = 2;
   localparam int KIND_WIDTH   = 2;
   localparam int FLAGS_WIDTH  = KIND_WIDTH + 1 + PEER_WIDTH;
   localparam int ENTRY_WIDTH  = DOMAIN_WIDTH + FRAME_WIDTH + FLAGS_WIDTH;

   localparam logic [ACTION_WIDTH-1:0] ACT_GRANT_ACCESS   = 3'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_GRANT_TRANSFER = 3'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_END_ACCESS     = 3'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_END_TRANSFER   = 3'd3;
   localparam logic [ACTION_WIDTH-1:0] ACT_PEER_UPDATE    = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_IN_USE  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_PENDING = 2'd3;

   localparam logic [KIND_WIDTH-1:0] KIND_FREE     = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_ACCESS   = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_TRANSFER = 2'd2;

   // positions inside the entry flags
   localparam int FLAG_RDONLY_BIT    = 2;
   localparam int FLAG_READING_BIT   = 3;
   localparam int FLAG_WRITING_BIT   = 4;
   localparam int FLAG_COMMITTED_BIT = 5;
   localparam int FLAG_COMPLETED_BIT = 6;

   // completed bit inside peer_bits
   localparam int PEER_COMPLETED_BIT = 3;

endpackage

@@ design/gra_ram.sv @@
module gra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/grant_reference_allocator_core.sv @@
// grant reference allocator core
//
// command channel: a word is taken at a rising edge with start high and busy
// low. the word carries an action (grant access, grant transfer, end access,
// end transfer, peer update) and its operands.
// result channel: one result word per command, shown on the rsp_ ports for
// exactly one cycle while rsp_valid is high. the receiver cannot stall it.
//
// the command is registered at the accepting edge, together with the reads of
// the link and entry memories; in the exec state the result is formed and then
// registered. busy is high in the exec state, so a new command cannot be taken
// while one is in flight: the read of the link and entry memories is followed
// by the dependent head update and write back.
//
// reset (synchronous, active high) puts the free list in its initial chain
// at once: no clearing pass is run. entries below a low-water mark that have
// never been handed out read as their initial link and as free, so the
// memories need no initialization. a command can be taken in the first
// cycle after reset is released.
module grant_reference_allocator_core #(
   parameter int ENTRY_COUNT    = gra_pkg::ENTRY_COUNT_DEFAULT,
   parameter int RESERVED_COUNT = gra_pkg::RESERVED_COUNT_DEFAULT,
   localparam int REF_WIDTH     = $clog2(ENTRY_COUNT),
   localparam int COUNT_WIDTH   = $clog2(ENTRY_COUNT + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [gra_pkg::ACTION_WIDTH-1:0]  req_action,
   input  logic [gra_pkg::DOMAIN_WIDTH-1:0]  req_target_domain,
   input  logic [gra_pkg::FRAME_WIDTH-1:0]   req_frame_number,
   input  logic                              req_read_only,
   input  logic [REF_WIDTH-1:0]              req_entry_ref,
   input  logic [gra_pkg::PEER_WIDTH-1:0]    req_peer_bits,
   output logic                              rsp_valid,
   output logic [REF_WIDTH-1:0]              rsp_granted_ref,
   output logic [gra_pkg::FRAME_WIDTH-1:0]   rsp_returned_frame,
   output logic [gra_pkg::STATUS_WIDTH-1:0]  rsp_status,
   output logic [COUNT_WIDTH-1:0]            rsp_free_count
);

   import gra_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;

   logic [REF_WIDTH-1:0]   head_ff, head_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [REF_WIDTH:0]     mark_ff, mark_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [REF_WIDTH-1:0]    granted_ff, granted_in;
   logic [FRAME_WIDTH-1:0]  ret_frame_ff, ret_frame_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;

   logic [ACTION_WIDTH-1:0] action_ff;
   logic [DOMAIN_WIDTH-1:0] domain_ff;
   logic [FRAME_WIDTH-1:0]  frame_ff;
   logic                    ro_ff;
   logic [REF_WIDTH-1:0]    ref_ff;
   logic [PEER_WIDTH-1:0]   peer_ff;
   logic                    in_range_ff;

   logic accept;
   logic req_in_range;

   logic                   links_we;
   logic [REF_WIDTH-1:0]   links_waddr;
   logic [REF_WIDTH-1:0]   links_wdata;
   logic [REF_WIDTH-1:0]   links_q;

   logic                   entry_we;
   logic [REF_WIDTH-1:0]   entry_waddr;
   logic [ENTRY_WIDTH-1:0] entry_wdata;
   logic [ENTRY_WIDTH-1:0] entry_q;

   logic                    head_fresh;
   logic                    ref_fresh;
   logic [REF_WIDTH-1:0]    link_rd;
   logic [FLAGS_WIDTH-1:0]  flags_rd;
   logic [FRAME_WIDTH-1:0]  frame_rd;
   logic [DOMAIN_WIDTH-1:0] domain_rd;
   logic [FLAGS_WIDTH-1:0]  grant_flags;
   logic                    push;

   assign busy   = (state_ff == ST_EXEC);
   assign accept = start && !busy;

   assign req_in_range = (32'(req_entry_ref) >= 32'(RESERVED_COUNT)) &&
                         (32'(req_entry_ref) < 32'(ENTRY_COUNT));

   gra_ram #(
      .WIDTH (REF_WIDTH),
      .DEPTH (ENTRY_COUNT)
   ) u_links_ram (
      .clock   (clock),
      .wr_en   (links_we),
      .wr_addr (links_waddr),
      .wr_data (links_wdata),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (links_q)
   );

   gra_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (ENTRY_COUNT)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_we),
      .wr_addr (entry_waddr),
      .wr_data (entry_wdata),
      .rd_en   (accept),
      .rd_addr (req_entry_ref),
      .rd_data (entry_q)
   );

   // entries below the mark were never handed out
   assign head_fresh = ({1'b0, head_ff} < mark_ff);
   assign ref_fresh  = ({1'b0, ref_ff} < mark_ff);

   always_comb begin
      if (!head_fresh) begin
         link_rd = links_q;
      end else if (head_ff == REF_WIDTH'(RESERVED_COUNT)) begin
         link_rd = '0;
      end else begin
         link_rd = head_ff - REF_WIDTH'(1);
      end
   end

   assign domain_rd = entry_q[ENTRY_WIDTH-1 -: DOMAIN_WIDTH];
   assign frame_rd  = entry_q[FLAGS_WIDTH +: FRAME_WIDTH];
   assign flags_rd  = ref_fresh ? '0 : entry_q[FLAGS_WIDTH-1:0];

   always_comb begin
      grant_flags = '0;
      if (action_ff == ACT_GRANT_ACCESS) begin
         grant_flags[KIND_WIDTH-1:0]  = KIND_ACCESS;
         grant_flags[FLAG_RDONLY_BIT] = ro_ff;
      end else begin
         grant_flags[KIND_WIDTH-1:0] = KIND_TRANSFER;
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      total_in     = total_ff;
      mark_in      = mark_ff;
      rsp_valid_in = 1'b0;
      granted_in   = '0;
      ret_frame_in = '0;
      status_in    = STATUS_OK;
      links_we     = 1'b0;
      links_waddr  = ref_ff;
      links_wdata  = head_ff;
      entry_we     = 1'b0;
      entry_waddr  = ref_ff;
      entry_wdata  = {domain_rd, frame_rd, flags_rd};
      push         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            case (action_ff)
               ACT_GRANT_ACCESS, ACT_GRANT_TRANSFER: begin
                  if (total_ff == '0) begin
                     status_in = STATUS_NO_FREE;
                  end else begin
                     entry_we    = 1'b1;
                     entry_waddr = head_ff;
                     entry_wdata = {domain_ff, frame_ff, grant_flags};
                     head_in     = link_rd;
                     total_in    = total_ff - COUNT_WIDTH'(1);
                     granted_in  = head_ff;
                     if (head_fresh) begin
                        mark_in = {1'b0, head_ff};
                     end
                  end
               end
               ACT_END_ACCESS: begin
                  if (in_range_ff && flags_rd[KIND_WIDTH-1:0] != KIND_FREE) begin
                     if (flags_rd[FLAG_READING_BIT] || flags_rd[FLAG_WRITING_BIT]) begin
                        status_in = STATUS_IN_USE;
                     end else begin
                        push = 1'b1;
                     end
                  end
               end
               ACT_END_TRANSFER: begin
                  if (in_range_ff && flags_rd[KIND_WIDTH-1:0] != KIND_FREE) begin
                     if (!flags_rd[FLAG_COMMITTED_BIT]) begin
                        push = 1'b1;
                     end else if (!flags_rd[FLAG_COMPLETED_BIT]) begin
                        status_in = STATUS_PENDING;
                     end else begin
                        ret_frame_in = frame_rd;
                        push         = 1'b1;
                     end
                  end
               end
               ACT_PEER_UPDATE: begin
                  if (in_range_ff) begin
                     entry_we    = 1'b1;
                     entry_wdata = {domain_rd,
                                    peer_ff[PEER_COMPLETED_BIT] ? frame_ff : frame_rd,
                                    peer_ff, flags_rd[FLAG_RDONLY_BIT:0]};
                  end
               end
               default: begin
               end
            endcase
            if (push) begin
               entry_we    = 1'b1;
               entry_wdata = {domain_rd, frame_rd, {FLAGS_WIDTH{1'b0}}};
               links_we    = 1'b1;
               head_in     = ref_ff;
               total_in    = total_ff + COUNT_WIDTH'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= REF_WIDTH'(ENTRY_COUNT - 1);
         total_ff     <= COUNT_WIDTH'(ENTRY_COUNT - RESERVED_COUNT);
         mark_ff      <= (REF_WIDTH + 1)'(ENTRY_COUNT);
         rsp_valid_ff <= 1'b0;
         granted_ff   <= '0;
         ret_frame_ff <= '0;
         status_ff    <= STATUS_OK;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
         granted_ff   <= granted_in;
         ret_frame_ff <= ret_frame_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff   <= req_action;
         domain_ff   <= req_target_domain;
         frame_ff    <= req_frame_number;
         ro_ff       <= req_read_only;
         ref_ff      <= req_entry_ref;
         peer_ff     <= req_peer_bits;
         in_range_ff <= req_in_range;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_ref    = granted_ff;
   assign rsp_returned_frame = ret_frame_ff;
   assign rsp_status         = status_ff;
   assign rsp_free_count     = total_ff;

endmodule
